@@ rtl/blm_pkg.sv @@
// blm_pkg: shared types and constants for the bilinear map lookup block.
// Used by blm_store, bilinear_map_lookup and the bench; depends on nothing.

package blm_pkg;

    localparam int OPCODE_W = 3;
    localparam int INDEX_W  = 10;
    localparam int ENTRY_W  = 16;
    localparam int QUERY_W  = 24;
    localparam int RESULT_W = 24;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [OPCODE_W-1:0] OP_WR_X    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_WR_Y    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_WR_CELL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FWD     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_INV     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_X_COUNT = 1'b0;
    localparam logic CFG_Y_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_BASE,
        S_FETCH_RD,
        S_FETCH_CAP,
        S_LERP_LOAD,
        S_LERP_PREP,
        S_LERP_GO,
        S_LERP_WAIT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_FX,
        PH_FY,
        PH_IY,
        PH_IROW
    } t_phase;

    typedef enum logic [1:0] {
        SRC_X,
        SRC_Y,
        SRC_ROW
    } t_src;

    typedef struct packed {
        logic x;
        logic y;
        logic g;
    } t_wr_sel;

endpackage

@@ rtl/blm_store.sv @@
// blm_store: x axis, y axis and cell grid memories, one write and one
// registered read port each. Depends on blm_pkg.

module blm_store #(
    parameter int MAX_X_POINTS = 32,
    parameter int MAX_Y_POINTS = 32
) (
    input  logic                                  i_clk,
    input  blm_pkg::t_wr_sel                      i_wr,
    input  logic [$clog2(MAX_X_POINTS)-1:0]       i_x_waddr,
    input  logic [$clog2(MAX_Y_POINTS)-1:0]       i_y_waddr,
    input  logic [$clog2(MAX_X_POINTS*MAX_Y_POINTS)-1:0] i_g_waddr,
    input  logic signed [blm_pkg::ENTRY_W-1:0]    i_wdata,
    input  logic [$clog2(MAX_X_POINTS)-1:0]       i_x_raddr,
    input  logic [$clog2(MAX_Y_POINTS)-1:0]       i_y_raddr,
    input  logic [$clog2(MAX_X_POINTS*MAX_Y_POINTS)-1:0] i_g_raddr,
    output logic signed [blm_pkg::ENTRY_W-1:0]    o_x_rdata,
    output logic signed [blm_pkg::ENTRY_W-1:0]    o_y_rdata,
    output logic signed [blm_pkg::ENTRY_W-1:0]    o_g_rdata
);

    localparam int GRID = MAX_X_POINTS * MAX_Y_POINTS;

    logic signed [blm_pkg::ENTRY_W-1:0] r_x_mem [MAX_X_POINTS];
    logic signed [blm_pkg::ENTRY_W-1:0] r_y_mem [MAX_Y_POINTS];
    logic signed [blm_pkg::ENTRY_W-1:0] r_g_mem [GRID];

    always_ff @(posedge i_clk) begin
        if (i_wr.x) begin
            r_x_mem[i_x_waddr] <= i_wdata;
        end
        o_x_rdata <= r_x_mem[i_x_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.y) begin
            r_y_mem[i_y_waddr] <= i_wdata;
        end
        o_y_rdata <= r_y_mem[i_y_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.g) begin
            r_g_mem[i_g_waddr] <= i_wdata;
        end
        o_g_rdata <= r_g_mem[i_g_raddr];
    end

endmodule

@@ rtl/blm_muldiv.sv @@
// blm_muldiv: serial floor(a*b/d) on magnitudes, shift-add multiply then
// restoring divide, one bit a cycle. Depends on nothing outside itself.

module blm_muldiv #(
    parameter int MW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [MW-1:0] i_a,
    input  logic [MW-1:0] i_b,
    input  logic [MW-1:0] i_d,
    output logic          o_done,
    output logic [MW-1:0] o_q
);

    localparam int CNW = $clog2(2 * MW);

    logic            r_busy, n_busy;
    logic            r_mul, n_mul;
    logic            r_done, n_done;
    logic [CNW-1:0]  r_cnt, n_cnt;
    logic [MW-1:0]   r_a, n_a;
    logic [MW-1:0]   r_b, n_b;
    logic [MW-1:0]   r_d, n_d;
    logic [2*MW-1:0] r_p, n_p;
    logic [MW-1:0]   r_r, n_r;
    logic [MW:0]     rs;
    logic            ge;

    always_comb begin
        n_busy = r_busy;
        n_mul  = r_mul;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_d    = r_d;
        n_p    = r_p;
        n_r    = r_r;
        rs     = {r_r, r_p[2*MW-1]};
        ge     = (rs >= {1'b0, r_d});
        if (i_start) begin
            n_busy = 1'b1;
            n_mul  = 1'b1;
            n_cnt  = CNW'(MW - 1);
            n_a    = i_a;
            n_b    = i_b;
            n_d    = i_d;
            n_p    = '0;
            n_r    = '0;
        end else if (r_busy) begin
            if (r_mul) begin
                n_p = {r_p[2*MW-2:0], 1'b0} + (r_b[MW-1] ? {{MW{1'b0}}, r_a} : '0);
                n_b = {r_b[MW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_mul = 1'b0;
                    n_cnt = CNW'(2 * MW - 1);
                end else begin
                    n_cnt = r_cnt - CNW'(1);
                end
            end else begin
                // quotient bits shift in behind the numerator
                n_r = ge ? MW'(rs - {1'b0, r_d}) : rs[MW-1:0];
                n_p = {r_p[2*MW-2:0], ge};
                if (r_cnt == '0) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - CNW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= n_mul;
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_b   <= n_b;
        r_d   <= n_d;
        r_p   <= n_p;
        r_r   <= n_r;
    end

    assign o_done = r_done;
    assign o_q    = r_p[MW-1:0];

endmodule

@@ rtl/bilinear_map_lookup.sv @@
// bilinear_map_lookup: 2-D calibration map with forward bilinear and inverse
// lookup. Depends on blm_pkg, blm_store and blm_muldiv.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_stall | opcode, entry_index, entry_value,
//          |           |                         | query_x, query_y
//  out     | from block| o_out_valid/i_out_stall | result_value, status
//  cfg     | to block  | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One beat at a time: a write or a lookup finishes before another beat is accepted.
// A lookup scans its breakpoints entry by entry (forward: x then y axis;
// inverse: y axis then a grid row), fetches the cells it needs and runs up
// to three interpolations in the serial mul/divide unit: three for forward,
// one for inverse.
// Synchronous active-low reset clears control and the counts (x 0, y 1).
// A finished beat waits in the output register while i_out_stall is high.

module bilinear_map_lookup #(
    parameter int MAX_X_POINTS = 32,
    parameter int MAX_Y_POINTS = 32,
    parameter int FRAC_BITS    = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [blm_pkg::OPCODE_W-1:0]           i_opcode,
    input  logic [blm_pkg::INDEX_W-1:0]            i_entry_index,
    input  logic signed [blm_pkg::ENTRY_W-1:0]     i_entry_value,
    input  logic signed [blm_pkg::QUERY_W-1:0]     i_query_x,
    input  logic signed [blm_pkg::QUERY_W-1:0]     i_query_y,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [blm_pkg::RESULT_W-1:0]    o_result_value,
    output logic [blm_pkg::STATUS_W-1:0]           o_status,
    input  logic                                   i_cfg_we,
    input  logic                                   i_cfg_index,
    input  logic [blm_pkg::COUNT_W-1:0]            i_cfg_data
);

    localparam int XIW  = $clog2(MAX_X_POINTS);
    localparam int YIW  = $clog2(MAX_Y_POINTS);
    localparam int GRID = MAX_X_POINTS * MAX_Y_POINTS;
    localparam int GIW  = $clog2(GRID);
    localparam int XNW  = $clog2(MAX_X_POINTS + 1);
    localparam int YNW  = $clog2(MAX_Y_POINTS + 1);
    localparam int NW   = (XNW > YNW) ? XNW : YNW;
    localparam int SIW  = (XIW > YIW) ? XIW : YIW;
    localparam int BPW  = YIW + XNW;
    localparam int SW   = blm_pkg::ENTRY_W + FRAC_BITS;
    localparam int PW   = (blm_pkg::QUERY_W > SW) ? blm_pkg::QUERY_W : SW;
    localparam int VW   = PW + 2;
    localparam int MW   = SW;
    localparam int EW   = blm_pkg::ENTRY_W;
    localparam int RW   = blm_pkg::RESULT_W;

    function automatic logic signed [VW-1:0] scl(input logic signed [EW-1:0] e);
        scl = $signed({{(VW-EW){e[EW-1]}}, e}) <<< FRAC_BITS;
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [VW-1:0] v);
        logic [VW-1:0] a;
        a   = v[VW-1] ? VW'(-v) : VW'(v);
        mag = a[MW-1:0];
    endfunction

    blm_pkg::t_state r_state, n_state;
    blm_pkg::t_phase r_phase, n_phase;
    blm_pkg::t_src   r_src, n_src;

    logic [blm_pkg::COUNT_W-1:0] r_x_cnt, r_y_cnt;
    logic [XNW-1:0] xn;
    logic [YNW-1:0] yn;

    logic [blm_pkg::OPCODE_W-1:0]  r_op, n_op;
    logic [blm_pkg::INDEX_W-1:0]   r_idx, n_idx;
    logic signed [EW-1:0]          r_val, n_val;
    logic signed [VW-1:0]          r_qx, n_qx, r_qy, n_qy;
    logic [SIW-1:0]                r_si, n_si;
    logic [NW-1:0]                 r_n, n_n;
    logic signed [VW-1:0]          r_v, n_v;
    logic signed [EW-1:0]          r_prev, n_prev;
    logic [XIW-1:0]                r_xl, n_xl, r_xh, n_xh;
    logic signed [EW-1:0]          r_xlv, n_xlv, r_xhv, n_xhv;
    logic [YIW-1:0]                r_yl, n_yl, r_yh, n_yh;
    logic signed [EW-1:0]          r_ylv, n_ylv, r_yhv, n_yhv;
    logic [GIW-1:0]                r_base, n_base, r_base_h, n_base_h;
    logic [1:0]                    r_fk, n_fk, r_lk, n_lk;
    logic signed [EW-1:0]          r_c [4];
    logic signed [EW-1:0]          n_c [4];
    logic signed [VW-1:0]          r_f1, n_f1, r_f2, n_f2, r_x1, n_x1, r_x2, n_x2;
    logic signed [VW-1:0]          r_lv, n_lv;
    logic signed [VW-1:0]          r_d, n_d, r_t, n_t, r_df, n_df;
    logic                          r_neg, n_neg;
    logic signed [VW-1:0]          r_lo, n_lo, r_hi, n_hi, r_res, n_res;
    logic [blm_pkg::STATUS_W-1:0]  r_status, n_status;
    logic                          r_out_valid, n_out_valid;
    logic signed [RW-1:0]          r_out_res, n_out_res;
    logic [blm_pkg::STATUS_W-1:0]  r_out_st, n_out_st;

    blm_pkg::t_wr_sel              wr;
    logic [XIW-1:0]                x_raddr;
    logic [YIW-1:0]                y_raddr;
    logic [GIW-1:0]                g_raddr;
    logic signed [EW-1:0]          x_rd, y_rd, g_rd, rd;
    logic signed [VW-1:0]          sv;
    logic                          fnd;
    logic [SIW-1:0]                f_lo, f_hi;
    logic signed [EW-1:0]          f_lv, f_hv;
    logic [BPW-1:0]                base_prod;
    logic signed [VW-1:0]          tc;
    logic                          md_start, md_done;
    logic [MW-1:0]                 md_q;
    logic                          lfin;
    logic signed [VW-1:0]          lres;
    logic                          in_acc;
    logic [1:0]                    last_fk;

    // effective counts: x saturates, y also treats zero as one
    always_comb begin
        if (r_x_cnt > MAX_X_POINTS) xn = XNW'(MAX_X_POINTS);
        else                        xn = XNW'(r_x_cnt);
        if (r_y_cnt == '0)              yn = YNW'(1);
        else if (r_y_cnt > MAX_Y_POINTS) yn = YNW'(MAX_Y_POINTS);
        else                             yn = YNW'(r_y_cnt);
    end

    assign in_acc     = i_in_valid && (r_state == blm_pkg::S_IDLE);
    assign o_in_stall = (r_state != blm_pkg::S_IDLE);
    assign base_prod  = BPW'(r_yl) * BPW'(xn);
    assign last_fk    = (r_op == blm_pkg::OP_FWD) ? 2'd3 : 2'd1;

    always_comb begin
        if (r_state == blm_pkg::S_FETCH_RD) begin
            x_raddr = r_fk[0] ? r_xh : r_xl;
            g_raddr = (r_fk[1] ? r_base_h : r_base) + GIW'(r_fk[0] ? r_xh : r_xl);
        end else begin
            x_raddr = r_si[XIW-1:0];
            g_raddr = r_base + GIW'(r_si);
        end
        y_raddr = r_si[YIW-1:0];
        case (r_src)
            blm_pkg::SRC_X:   rd = x_rd;
            blm_pkg::SRC_Y:   rd = y_rd;
            blm_pkg::SRC_ROW: rd = g_rd;
            default:          rd = x_rd;
        endcase
        wr.x = (r_state == blm_pkg::S_WRITE) && (r_status == blm_pkg::ST_OK)
               && (r_op == blm_pkg::OP_WR_X);
        wr.y = (r_state == blm_pkg::S_WRITE) && (r_status == blm_pkg::ST_OK)
               && (r_op == blm_pkg::OP_WR_Y);
        wr.g = (r_state == blm_pkg::S_WRITE) && (r_status == blm_pkg::ST_OK)
               && (r_op == blm_pkg::OP_WR_CELL);
    end

    blm_store #(
        .MAX_X_POINTS(MAX_X_POINTS),
        .MAX_Y_POINTS(MAX_Y_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_x_waddr (r_idx[XIW-1:0]),
        .i_y_waddr (r_idx[YIW-1:0]),
        .i_g_waddr (GIW'(r_idx)),
        .i_wdata   (r_val),
        .i_x_raddr (x_raddr),
        .i_y_raddr (y_raddr),
        .i_g_raddr (g_raddr),
        .o_x_rdata (x_rd),
        .o_y_rdata (y_rd),
        .o_g_rdata (g_rd)
    );

    blm_muldiv #(
        .MW(MW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (md_start),
        .i_a     (mag(r_df)),
        .i_b     (mag(tc)),
        .i_d     (mag(r_d)),
        .o_done  (md_done),
        .o_q     (md_q)
    );

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_src       = r_src;
        n_op        = r_op;
        n_idx       = r_idx;
        n_val       = r_val;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_si        = r_si;
        n_n         = r_n;
        n_v         = r_v;
        n_prev      = r_prev;
        n_xl        = r_xl;
        n_xh        = r_xh;
        n_xlv       = r_xlv;
        n_xhv       = r_xhv;
        n_yl        = r_yl;
        n_yh        = r_yh;
        n_ylv       = r_ylv;
        n_yhv       = r_yhv;
        n_base      = r_base;
        n_base_h    = r_base_h;
        n_fk        = r_fk;
        n_lk        = r_lk;
        n_c         = r_c;
        n_f1        = r_f1;
        n_f2        = r_f2;
        n_x1        = r_x1;
        n_x2        = r_x2;
        n_lv        = r_lv;
        n_d         = r_d;
        n_t         = r_t;
        n_df        = r_df;
        n_neg       = r_neg;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_res       = r_res;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_res   = r_out_res;
        n_out_st    = r_out_st;
        sv          = scl(rd);
        fnd         = 1'b0;
        f_lo        = r_si;
        f_hi        = r_si;
        f_lv        = rd;
        f_hv        = rd;
        md_start    = 1'b0;
        lfin        = 1'b0;
        lres        = r_f1;

        // clamp the offset into the bracket span
        tc = r_t;
        if (!r_d[VW-1]) begin
            if (r_t[VW-1])      tc = '0;
            else if (r_t > r_d) tc = r_d;
        end else begin
            if (!r_t[VW-1] && r_t != '0) tc = '0;
            else if (r_t < r_d)          tc = r_d;
        end

        case (r_state)
            blm_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_opcode;
                    n_idx    = i_entry_index;
                    n_val    = i_entry_value;
                    n_qx     = {{(VW-blm_pkg::QUERY_W){i_query_x[blm_pkg::QUERY_W-1]}},
                                i_query_x};
                    n_qy     = {{(VW-blm_pkg::QUERY_W){i_query_y[blm_pkg::QUERY_W-1]}},
                                i_query_y};
                    n_res    = '0;
                    n_status = blm_pkg::ST_OK;
                    n_si     = '0;
                    n_state  = blm_pkg::S_DONE;
                    case (i_opcode)
                        blm_pkg::OP_WR_X: begin
                            if (i_entry_index >= MAX_X_POINTS) n_status = blm_pkg::ST_RANGE;
                            n_state = blm_pkg::S_WRITE;
                        end
                        blm_pkg::OP_WR_Y: begin
                            if (i_entry_index >= MAX_Y_POINTS) n_status = blm_pkg::ST_RANGE;
                            n_state = blm_pkg::S_WRITE;
                        end
                        blm_pkg::OP_WR_CELL: begin
                            if (i_entry_index >= GRID) n_status = blm_pkg::ST_RANGE;
                            n_state = blm_pkg::S_WRITE;
                        end
                        blm_pkg::OP_FWD: begin
                            if (xn == '0) begin
                                n_status = blm_pkg::ST_EMPTY;
                            end else begin
                                n_phase = blm_pkg::PH_FX;
                                n_src   = blm_pkg::SRC_X;
                                n_n     = NW'(xn);
                                n_v     = n_qx;
                                n_state = blm_pkg::S_SRCH_RD;
                            end
                        end
                        blm_pkg::OP_INV: begin
                            if (xn == '0) begin
                                n_status = blm_pkg::ST_EMPTY;
                            end else begin
                                n_phase = blm_pkg::PH_IY;
                                n_src   = blm_pkg::SRC_Y;
                                n_n     = NW'(yn);
                                n_v     = n_qy;
                                n_state = blm_pkg::S_SRCH_RD;
                            end
                        end
                        default: n_state = blm_pkg::S_DONE;
                    endcase
                end
            end

            blm_pkg::S_WRITE: begin
                n_state = blm_pkg::S_DONE;
            end

            blm_pkg::S_SRCH_RD: begin
                n_state = blm_pkg::S_SRCH_CMP;
            end

            blm_pkg::S_SRCH_CMP: begin
                if (r_si == '0) begin
                    if (r_n <= NW'(1) || r_v <= sv) begin
                        fnd = 1'b1;
                    end else begin
                        n_prev  = rd;
                        n_si    = SIW'(1);
                        n_state = blm_pkg::S_SRCH_RD;
                    end
                end else if (sv >= r_v) begin
                    fnd  = 1'b1;
                    f_lo = r_si - SIW'(1);
                    f_lv = r_prev;
                end else if ((NW'(r_si) + NW'(1)) == r_n) begin
                    fnd = 1'b1;     // past the last entry: clamp to edge
                end else begin
                    n_prev  = rd;
                    n_si    = r_si + SIW'(1);
                    n_state = blm_pkg::S_SRCH_RD;
                end

                if (fnd) begin
                    case (r_phase)
                        blm_pkg::PH_FX: begin
                            n_xl    = f_lo[XIW-1:0];
                            n_xh    = f_hi[XIW-1:0];
                            n_xlv   = f_lv;
                            n_xhv   = f_hv;
                            n_phase = blm_pkg::PH_FY;
                            n_src   = blm_pkg::SRC_Y;
                            n_n     = NW'(yn);
                            n_v     = r_qy;
                            n_si    = '0;
                            n_state = blm_pkg::S_SRCH_RD;
                        end
                        blm_pkg::PH_FY, blm_pkg::PH_IY: begin
                            n_yl    = f_lo[YIW-1:0];
                            n_yh    = f_hi[YIW-1:0];
                            n_ylv   = f_lv;
                            n_yhv   = f_hv;
                            n_state = blm_pkg::S_BASE;
                        end
                        default: begin
                            n_xl    = f_lo[XIW-1:0];
                            n_xh    = f_hi[XIW-1:0];
                            n_xlv   = f_lv;
                            n_xhv   = f_hv;
                            n_src   = blm_pkg::SRC_X;
                            n_fk    = '0;
                            n_state = blm_pkg::S_FETCH_RD;
                        end
                    endcase
                end
            end

            blm_pkg::S_BASE: begin
                n_base   = GIW'(base_prod);
                n_base_h = GIW'(base_prod) + ((r_yh != r_yl) ? GIW'(xn) : '0);
                n_src    = blm_pkg::SRC_ROW;
                if (r_op == blm_pkg::OP_FWD) begin
                    n_fk    = '0;
                    n_state = blm_pkg::S_FETCH_RD;
                end else begin
                    n_phase = blm_pkg::PH_IROW;
                    n_n     = NW'(xn);
                    n_v     = r_qx;
                    n_si    = '0;
                    n_state = blm_pkg::S_SRCH_RD;
                end
            end

            blm_pkg::S_FETCH_RD: begin
                n_state = blm_pkg::S_FETCH_CAP;
            end

            blm_pkg::S_FETCH_CAP: begin
                n_c[r_fk] = rd;
                if (r_fk == last_fk) begin
                    n_lk    = '0;
                    n_state = blm_pkg::S_LERP_LOAD;
                end else begin
                    n_fk    = r_fk + 2'd1;
                    n_state = blm_pkg::S_FETCH_RD;
                end
            end

            blm_pkg::S_LERP_LOAD: begin
                case (r_lk)
                    2'd2: begin
                        n_f1 = r_lo;
                        n_f2 = r_hi;
                        n_x1 = scl(r_ylv);
                        n_x2 = scl(r_yhv);
                        n_lv = r_qy;
                    end
                    2'd1: begin
                        n_f1 = scl(r_c[2]);
                        n_f2 = scl(r_c[3]);
                        n_x1 = scl(r_xlv);
                        n_x2 = scl(r_xhv);
                        n_lv = r_qx;
                    end
                    default: begin
                        n_f1 = scl(r_c[0]);
                        n_f2 = scl(r_c[1]);
                        n_x1 = scl(r_xlv);
                        n_x2 = scl(r_xhv);
                        n_lv = r_qx;
                    end
                endcase
                n_state = blm_pkg::S_LERP_PREP;
            end

            blm_pkg::S_LERP_PREP: begin
                n_d     = r_x2 - r_x1;
                n_t     = r_lv - r_x1;
                n_df    = r_f2 - r_f1;
                n_state = blm_pkg::S_LERP_GO;
            end

            blm_pkg::S_LERP_GO: begin
                if (r_d == '0 || r_df == '0 || tc == '0) begin
                    lfin = 1'b1;
                end else begin
                    md_start = 1'b1;
                    n_neg    = r_df[VW-1] ^ tc[VW-1] ^ r_d[VW-1];
                    n_state  = blm_pkg::S_LERP_WAIT;
                end
            end

            blm_pkg::S_LERP_WAIT: begin
                if (md_done) begin
                    lfin = 1'b1;
                    lres = r_neg ? (r_f1 - $signed(VW'(md_q))) : (r_f1 + $signed(VW'(md_q)));
                end
            end

            blm_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_status;
                    if (&r_res[VW-1:RW-1] || ~|r_res[VW-1:RW-1]) begin
                        n_out_res = r_res[RW-1:0];
                    end else if (r_res[VW-1]) begin
                        n_out_res = {1'b1, {(RW-1){1'b0}}};
                    end else begin
                        n_out_res = {1'b0, {(RW-1){1'b1}}};
                    end
                    n_state = blm_pkg::S_IDLE;
                end
            end

            default: n_state = blm_pkg::S_IDLE;
        endcase

        if (lfin) begin
            if (r_op == blm_pkg::OP_FWD && r_lk == 2'd0) begin
                n_lo    = lres;
                n_lk    = 2'd1;
                n_state = blm_pkg::S_LERP_LOAD;
            end else if (r_op == blm_pkg::OP_FWD && r_lk == 2'd1) begin
                n_hi    = lres;
                n_lk    = 2'd2;
                n_state = blm_pkg::S_LERP_LOAD;
            end else begin
                n_res   = lres;
                n_state = blm_pkg::S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_cnt     <= '0;
            r_y_cnt     <= blm_pkg::COUNT_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    blm_pkg::CFG_X_COUNT: r_x_cnt <= i_cfg_data;
                    blm_pkg::CFG_Y_COUNT: r_y_cnt <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase   <= n_phase;
        r_src     <= n_src;
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_qx      <= n_qx;
        r_qy      <= n_qy;
        r_si      <= n_si;
        r_n       <= n_n;
        r_v       <= n_v;
        r_prev    <= n_prev;
        r_xl      <= n_xl;
        r_xh      <= n_xh;
        r_xlv     <= n_xlv;
        r_xhv     <= n_xhv;
        r_yl      <= n_yl;
        r_yh      <= n_yh;
        r_ylv     <= n_ylv;
        r_yhv     <= n_yhv;
        r_base    <= n_base;
        r_base_h  <= n_base_h;
        r_fk      <= n_fk;
        r_lk      <= n_lk;
        r_c       <= n_c;
        r_f1      <= n_f1;
        r_f2      <= n_f2;
        r_x1      <= n_x1;
        r_x2      <= n_x2;
        r_lv      <= n_lv;
        r_d       <= n_d;
        r_t       <= n_t;
        r_df      <= n_df;
        r_neg     <= n_neg;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_res     <= n_res;
        r_status  <= n_status;
        r_out_res <= n_out_res;
        r_out_st  <= n_out_st;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_st;

endmodule

@@ bench/bilinear_map_lookup_tb.sv @@
// Self-checking bench for bilinear_map_lookup: loads maps, runs directed and
// random forward/inverse lookups, and checks every result beat.
// Depends on rtl/blm_pkg.sv and the block itself.
`timescale 1ns / 100ps

module bilinear_map_lookup_tb;

    localparam int XCAP     = 32;
    localparam int YCAP     = 32;
    localparam int GRID_N   = XCAP * YCAP;
    localparam int IDLE_MAX = 5000;
    localparam int HOLD_LEN = 600;

    // Holds the map as the block should see it and the beats still owed.
    class map_scoreboard;
        shortint x_axis[XCAP];
        shortint y_axis[YCAP];
        shortint grid[GRID_N];
        int x_count;
        int y_count;
        logic signed [blm_pkg::RESULT_W-1:0] want_value[$];
        logic [blm_pkg::STATUS_W-1:0]        want_status[$];
        int errors;
        int checked;

        function new();
            foreach (x_axis[i]) x_axis[i] = 0;
            foreach (y_axis[i]) y_axis[i] = 0;
            foreach (grid[i]) grid[i] = 0;
            x_count = 0;
            y_count = 1;
            errors = 0;
            checked = 0;
        endfunction

        function int eff_x();
            return (x_count > XCAP) ? XCAP : x_count;
        endfunction

        function int eff_y();
            if (y_count == 0) return 1;
            return (y_count > YCAP) ? YCAP : y_count;
        endfunction

        function longint scale(shortint v);
            return longint'(v) * 256;
        endfunction

        function void bracket(input shortint a[XCAP], input int n, input longint v,
                              output int lo, output int hi);
            lo = 0;
            hi = 0;
            if (n <= 1 || v <= scale(a[0])) return;
            for (int i = 1; i < n; i++) begin
                if (scale(a[i]) >= v) begin
                    lo = i - 1;
                    hi = i;
                    return;
                end
            end
            lo = n - 1;
            hi = n - 1;
        endfunction

        function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint lerp(longint f1, longint f2, longint x1, longint x2, longint v);
            longint d, t, df, q;
            bit neg;
            if (x1 == x2) return f1;
            d = x2 - x1;
            t = v - x1;
            if (d > 0) begin
                if (t < 0) t = 0;
                if (t > d) t = d;
            end else begin
                if (t > 0) t = 0;
                if (t < d) t = d;
            end
            df = f2 - f1;
            if (df == 0 || t == 0) return f1;
            neg = (df < 0) ^ (t < 0) ^ (d < 0);
            q = (mag(df) * mag(t)) / mag(d);
            return neg ? f1 - q : f1 + q;
        endfunction

        function shortint grid_at(int idx);
            return (idx < GRID_N) ? grid[idx] : 16'sd0;
        endfunction

        function void note_input(logic [blm_pkg::OPCODE_W-1:0] op,
                                 logic [blm_pkg::INDEX_W-1:0] idx,
                                 logic signed [blm_pkg::ENTRY_W-1:0] val,
                                 logic signed [blm_pkg::QUERY_W-1:0] qx,
                                 logic signed [blm_pkg::QUERY_W-1:0] qy);
            longint res, lo_row, hi_row, vx, vy;
            logic [blm_pkg::STATUS_W-1:0] st;
            int xn, yn, xl, xh, yl, yh;
            shortint row[XCAP];
            res = 0;
            st = blm_pkg::ST_OK;
            xn = eff_x();
            yn = eff_y();
            vx = qx;
            vy = qy;
            case (op)
                blm_pkg::OP_WR_X:
                    if (idx < XCAP) x_axis[idx] = val; else st = blm_pkg::ST_RANGE;
                blm_pkg::OP_WR_Y:
                    if (idx < YCAP) y_axis[idx] = val; else st = blm_pkg::ST_RANGE;
                blm_pkg::OP_WR_CELL:
                    if (idx < GRID_N) grid[idx] = val; else st = blm_pkg::ST_RANGE;
                blm_pkg::OP_FWD, blm_pkg::OP_INV: begin
                    if (xn == 0) begin
                        st = blm_pkg::ST_EMPTY;
                    end else if (op == blm_pkg::OP_FWD) begin
                        bracket(x_axis, xn, vx, xl, xh);
                        bracket(y_axis, yn, vy, yl, yh);
                        lo_row = lerp(scale(grid_at(yl * xn + xl)),
                                      scale(grid_at(yl * xn + xh)),
                                      scale(x_axis[xl]), scale(x_axis[xh]), vx);
                        hi_row = lerp(scale(grid_at(yh * xn + xl)),
                                      scale(grid_at(yh * xn + xh)),
                                      scale(x_axis[xl]), scale(x_axis[xh]), vx);
                        res = lerp(lo_row, hi_row, scale(y_axis[yl]), scale(y_axis[yh]), vy);
                    end else begin
                        bracket(y_axis, yn, vy, yl, yh);
                        foreach (row[i]) row[i] = (i < xn) ? grid_at(yl * xn + i) : 16'sd0;
                        bracket(row, xn, vx, xl, xh);
                        res = lerp(scale(x_axis[xl]), scale(x_axis[xh]),
                                   scale(row[xl]), scale(row[xh]), vx);
                    end
                end
                default: ;
            endcase
            if (res > 64'sd8388607) res = 64'sd8388607;
            if (res < -64'sd8388608) res = -64'sd8388608;
            want_value.push_back(res[blm_pkg::RESULT_W-1:0]);
            want_status.push_back(st);
        endfunction

        function void check_result(logic signed [blm_pkg::RESULT_W-1:0] value,
                                   logic [blm_pkg::STATUS_W-1:0] st);
            logic signed [blm_pkg::RESULT_W-1:0] ev;
            logic [blm_pkg::STATUS_W-1:0] es;
            if (want_value.size() == 0) begin
                $display("%0t: unexpected result beat value %0d status %0d",
                         $realtime, value, st);
                errors++;
                return;
            end
            ev = want_value.pop_front();
            es = want_status.pop_front();
            checked++;
            if (value !== ev) begin
                $display("%0t: result_value expected %0d actual %0d", $realtime, ev, value);
                errors++;
            end
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $realtime, es, st);
                errors++;
            end
        endfunction

        function int pending();
            return want_value.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [blm_pkg::OPCODE_W-1:0]        i_opcode = blm_pkg::OP_WR_X;
    logic [blm_pkg::INDEX_W-1:0]         i_entry_index = '0;
    logic signed [blm_pkg::ENTRY_W-1:0]  i_entry_value = '0;
    logic signed [blm_pkg::QUERY_W-1:0]  i_query_x = '0;
    logic signed [blm_pkg::QUERY_W-1:0]  i_query_y = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [blm_pkg::RESULT_W-1:0] o_result_value;
    logic [blm_pkg::STATUS_W-1:0]        o_status;
    logic                                i_cfg_we = 1'b0;
    logic                                i_cfg_index = blm_pkg::CFG_X_COUNT;
    logic [blm_pkg::COUNT_W-1:0]         i_cfg_data = '0;

    map_scoreboard sb = new();
    bit  no_idle = 1'b0;
    bit  held_off = 1'b0;
    int  sent = 0;
    int  lookups = 0;
    int  idle_cycles = 0;

    bilinear_map_lookup dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_opcode, .i_entry_index,
        .i_entry_value, .i_query_x, .i_query_y, .o_out_valid, .i_out_stall,
        .o_result_value, .o_status, .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stall, plus one long hold-off to back the block up.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_result_value, o_status);
        if (!held_off && sb.checked == 150) begin
            held_off = 1'b1;
            stall_left = HOLD_LEN;
        end else if (stall_left == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX) begin
            $display("%0t: no beat accepted for %0d cycles", $realtime, IDLE_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic offer_item(logic [blm_pkg::OPCODE_W-1:0] op, int idx, int val,
                              int qx, int qy);
        logic [blm_pkg::INDEX_W-1:0]        ix;
        logic signed [blm_pkg::ENTRY_W-1:0] ev;
        logic signed [blm_pkg::QUERY_W-1:0] vx, vy;
        int g;
        ix = idx[blm_pkg::INDEX_W-1:0];
        ev = val[blm_pkg::ENTRY_W-1:0];
        vx = qx[blm_pkg::QUERY_W-1:0];
        vy = qy[blm_pkg::QUERY_W-1:0];
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_entry_index <= ix;
        i_entry_value <= ev;
        i_query_x     <= vx;
        i_query_y     <= vy;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, ix, ev, vx, vy);
        sent++;
        if (op == blm_pkg::OP_FWD || op == blm_pkg::OP_INV) lookups++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic set_counts(int xc, int yc);
        drain();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= blm_pkg::CFG_X_COUNT;
        i_cfg_data  <= xc[blm_pkg::COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= blm_pkg::CFG_Y_COUNT;
        i_cfg_data  <= yc[blm_pkg::COUNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.x_count = xc;
        sb.y_count = yc;
    endtask

    // Sorted axes (with the odd repeated breakpoint) and rows rising along x.
    task automatic load_map();
        int v, xn, yn;
        xn = sb.eff_x();
        yn = sb.eff_y();
        v = $urandom_range(0, 3000) - 3000;
        for (int i = 0; i < xn; i++) begin
            offer_item(blm_pkg::OP_WR_X, i, v, 0, 0);
            v += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 400);
        end
        v = $urandom_range(0, 3000) - 3000;
        for (int i = 0; i < yn; i++) begin
            offer_item(blm_pkg::OP_WR_Y, i, v, 0, 0);
            v += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 400);
        end
        for (int r = 0; r < yn; r++) begin
            v = $urandom_range(0, 20000) - 20000;
            for (int c = 0; c < xn; c++) begin
                offer_item(blm_pkg::OP_WR_CELL, r * xn + c, v, 0, 0);
                v += $urandom_range(0, 1100);
            end
        end
    endtask

    function automatic int near_axis(int lo_v, int hi_v);
        if ($urandom_range(0, 9) < 2) return $urandom;
        return (lo_v - 60 + int'($urandom_range(0, hi_v - lo_v + 120))) * 256
               + int'($urandom_range(0, 255));
    endfunction

    task automatic random_items(int count);
        int r, xn, yn, zl, zh, qx, qy, op_rand;
        xn = sb.eff_x();
        yn = sb.eff_y();
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            zl = (xn > 0) ? sb.grid[0] : 0;
            zh = (xn > 0) ? sb.grid[yn * xn - 1] : 0;
            if (zh < zl) zh = zl;
            qy = near_axis(sb.y_axis[0], (sb.y_axis[yn-1] > sb.y_axis[0]) ?
                           sb.y_axis[yn-1] : sb.y_axis[0]);
            if (r < 55) begin
                qx = near_axis(sb.x_axis[0], (xn > 0 && sb.x_axis[xn-1] > sb.x_axis[0]) ?
                               sb.x_axis[xn-1] : sb.x_axis[0]);
                offer_item(blm_pkg::OP_FWD, $urandom, $urandom, qx, qy);
            end else if (r < 80) begin
                offer_item(blm_pkg::OP_INV, $urandom, $urandom, near_axis(zl, zh), qy);
            end else if (r < 88) begin
                offer_item(blm_pkg::OP_WR_CELL, $urandom_range(0, GRID_N - 1), $urandom,
                           $urandom, $urandom);
            end else if (r < 92) begin
                offer_item($urandom_range(0, 1) ? blm_pkg::OP_WR_X : blm_pkg::OP_WR_Y,
                           $urandom_range(0, XCAP - 1), $urandom, $urandom, $urandom);
            end else if (r < 96) begin
                offer_item($urandom_range(0, 1) ? blm_pkg::OP_WR_X : blm_pkg::OP_WR_Y,
                           $urandom_range(XCAP, 1023), $urandom, $urandom, $urandom);
            end else begin
                op_rand = $urandom_range(5, 7);
                offer_item(op_rand[blm_pkg::OPCODE_W-1:0], $urandom, $urandom, $urandom,
                           $urandom);
            end
        end
    endtask

    // Edge queries: below, above and exactly on breakpoints, both directions.
    task automatic edge_queries();
        int xn, yn, zl, zh;
        xn = sb.eff_x();
        yn = sb.eff_y();
        if (xn == 0) begin
            offer_item(blm_pkg::OP_FWD, 0, 0, 0, 0);
            offer_item(blm_pkg::OP_INV, 0, 0, 0, 0);
            return;
        end
        zl = sb.grid[0];
        zh = sb.grid[xn - 1];
        offer_item(blm_pkg::OP_FWD, 0, 0, sb.x_axis[0] * 256 - 5000,
                   sb.y_axis[0] * 256 - 5000);
        offer_item(blm_pkg::OP_FWD, 0, 0, sb.x_axis[xn-1] * 256 + 5000,
                   sb.y_axis[yn-1] * 256 + 5000);
        offer_item(blm_pkg::OP_FWD, 0, 0, sb.x_axis[xn/2] * 256, sb.y_axis[yn/2] * 256);
        offer_item(blm_pkg::OP_INV, 0, 0, zl * 256 - 999, sb.y_axis[0] * 256);
        offer_item(blm_pkg::OP_INV, 0, 0, zh * 256 + 999, sb.y_axis[0] * 256 + 77);
        offer_item(blm_pkg::OP_INV, 0, 0, sb.grid[xn/2] * 256, sb.y_axis[0] * 256);
    endtask

    initial begin
        int settings[8][2] = '{'{1, 0}, '{2, 1}, '{4, 3}, '{63, 1}, '{1, 63},
                               '{0, 5}, '{5, 4}, '{3, 2}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty map, unknown opcodes, out-of-range writes, field extremes
        offer_item(blm_pkg::OP_FWD, 0, 0, 24'sh7FFFFF, -8388608);
        offer_item(blm_pkg::OP_INV, 1023, 32767, -8388608, 24'sh7FFFFF);
        offer_item(3'd5, 0, 0, 0, 0);
        offer_item(3'd6, 1023, -32768, -1, -1);
        offer_item(3'd7, 0, 0, 0, 0);
        offer_item(blm_pkg::OP_WR_X, XCAP, 32767, 0, 0);
        offer_item(blm_pkg::OP_WR_Y, 1023, -32768, 0, 0);
        offer_item(blm_pkg::OP_WR_CELL, 1023, -32768, 0, 0);

        foreach (settings[p]) begin
            set_counts(settings[p][0], settings[p][1]);
            no_idle = (p % 3 == 1);
            load_map();
            edge_queries();
            random_items(20);
        end

        drain();
        repeat (400) @(posedge i_clk);
        $display("Sent %0d beats (%0d lookups) over 8 map shapes, up to 32 points an axis;",
                 sent, lookups);
        $display("%0d result beats checked, %0d errors.", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
